### sv/otc_pkg.sv
package otc_pkg;

    // Command codes carried on the slave tuser field.
    typedef enum logic [3:0] {
        CMD_TICK   = 4'd0,
        CMD_MODE   = 4'd1,
        CMD_HEAT   = 4'd2,
        CMD_STOP   = 4'd3,
        CMD_UP     = 4'd4,
        CMD_DOWN   = 4'd5,
        CMD_RESET  = 4'd6,
        CMD_VIEW   = 4'd7,
        CMD_TEMP   = 4'd8
    } cmd_t;

    // Increment step codes.
    localparam logic [2:0] STEP_1S   = 3'd0;
    localparam logic [2:0] STEP_10S  = 3'd1;
    localparam logic [2:0] STEP_1M   = 3'd2;
    localparam logic [2:0] STEP_10M  = 3'd3;
    localparam logic [2:0] STEP_1H   = 3'd4;

    // Display view codes.
    localparam logic [1:0] VIEW_COOK  = 2'd0;
    localparam logic [1:0] VIEW_CLOCK = 2'd1;
    localparam logic [1:0] VIEW_IDLE  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_MAX_COOK = 1'b0;
    localparam logic CFG_BAND     = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [15:0] MAX_COOK_RESET = 16'd36000;
    localparam logic [9:0]  BAND_RESET     = 10'd10;

    // Time radix constants and reciprocals for the display split.
    localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
    localparam logic [4:0]  HOURS_PER_DAY  = 5'd24;
    localparam logic [15:0] RECIP_HOUR     = 16'd37283;  // ceil(2^27 / 3600)
    localparam logic [14:0] RECIP_MIN      = 15'd17477;  // ceil(2^20 / 60)

    // Status fields other than the remaining time, carried down the pipeline.
    typedef struct packed {
        logic       heater_on;
        logic       cooking_on;
        logic [4:0] clock_hours;
        logic [5:0] clock_minutes;
        logic [5:0] clock_seconds;
        logic [2:0] step_select;
        logic [1:0] view_select;
        logic       buzzer_pulse;
    } stat_t;

    // Countdown step in seconds; unused codes give no change.
    function automatic logic [11:0] step_size(input logic [2:0] mode);
        logic [11:0] size;
        begin
            case (mode)
                STEP_1S:  size = 12'd1;
                STEP_10S: size = 12'd10;
                STEP_1M:  size = 12'd60;
                STEP_10M: size = 12'd600;
                STEP_1H:  size = 12'd3600;
                default:  size = 12'd0;
            endcase
            return size;
        end
    endfunction

endpackage

### sv/oven_timer_thermostat_controller.sv
// Channel   Direction  Signals                               Contents
// s_axis    in         s_tvalid s_tready s_tuser s_tdata      one event per transaction
// m_axis    out        m_tvalid m_tready m_tdata              full status per transaction
// cfg       in         cfg_we cfg_index cfg_data              limit and band registers
//
// One transaction is accepted per cycle while s_tready is high; the controller state
// is updated in the accepting cycle. The status leaves a five-stage pipeline that
// splits the remaining time into hours, minutes and seconds.
// Each stage holds its data while the stage after it is full and stalled.
// Reset clears the controller state; the view starts idle and no pipeline stage is valid.
module oven_timer_thermostat_controller
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [3:0]  s_tuser,   // command
    input  logic [31:0] s_tdata,   // measured_temp[13:0], setpoint_temp[27:14], zero[31:28]
    output logic        m_tvalid,
    input  logic        m_tready,
    // heater_on[0], cooking_on[1], remain_hours[6:2], remain_minutes[12:7],
    // remain_seconds[18:13], clock_hours[23:19], clock_minutes[29:24],
    // clock_seconds[35:30], step_select[38:36], view_select[40:39],
    // buzzer_pulse[41], zero[47:42]
    output logic [47:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers.
    logic [15:0] max_cook_reg;
    logic [9:0]  band_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cook_reg <= otc_pkg::MAX_COOK_RESET;
            band_reg     <= otc_pkg::BAND_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == otc_pkg::CFG_MAX_COOK)
                max_cook_reg <= cfg_data;
            else
                band_reg <= cfg_data[9:0];
        end
    end

    // Controller state.
    logic [15:0] rt_reg, rt_next;
    logic        cook_reg, cook_next;
    logic        phase_reg, phase_next;
    logic        heater_reg, heater_next;
    logic [2:0]  step_reg, step_next;
    logic [1:0]  view_reg, view_next;
    logic [5:0]  tod_s_reg, tod_s_next;
    logic [5:0]  tod_m_reg, tod_m_next;
    logic [4:0]  tod_h_reg, tod_h_next;
    logic        buzz_next;

    logic        s_accept;
    logic [13:0] meas;
    logic [13:0] setp;

    assign meas = s_tdata[13:0];
    assign setp = s_tdata[27:14];

    // Helpers for the event update.
    logic [11:0] step_amt;
    logic [16:0] up_sum;
    logic [15:0] rt_dec;
    logic [14:0] meas_lo;
    logic [14:0] setp_hi;
    logic [6:0]  set_s;
    logic [6:0]  set_m;
    logic [5:0]  set_h;
    logic [3:0]  add_s;
    logic [3:0]  add_m;
    logic        add_h;
    logic        carry_s;
    logic        carry_m;

    always_comb
    begin
        step_amt = otc_pkg::step_size(step_reg);
        up_sum   = {1'b0, rt_reg} + {5'd0, step_amt};
        rt_dec   = rt_reg - 16'd1;
        meas_lo  = {1'b0, meas} + {5'd0, band_reg};
        setp_hi  = {1'b0, setp} + {5'd0, band_reg};

        // Clock setting: the selected digit is advanced, then carries ripple up.
        add_s = 4'd0;
        add_m = 4'd0;
        add_h = 1'b0;
        case (step_reg)
            otc_pkg::STEP_1S:  add_s = 4'd1;
            otc_pkg::STEP_10S: add_s = 4'd10;
            otc_pkg::STEP_1M:  add_m = 4'd1;
            otc_pkg::STEP_10M: add_m = 4'd10;
            otc_pkg::STEP_1H:  add_h = 1'b1;
            default:           add_s = 4'd0;
        endcase
        set_s   = {1'b0, tod_s_reg} + {3'd0, add_s};
        carry_s = (set_s >= {1'b0, otc_pkg::SECS_PER_MIN});
        if (carry_s)
            set_s = set_s - {1'b0, otc_pkg::SECS_PER_MIN};
        set_m   = {1'b0, tod_m_reg} + {3'd0, add_m} + {6'd0, carry_s};
        carry_m = (set_m >= {1'b0, otc_pkg::SECS_PER_MIN});
        if (carry_m)
            set_m = set_m - {1'b0, otc_pkg::SECS_PER_MIN};
        set_h = {1'b0, tod_h_reg} + {5'd0, add_h} + {5'd0, carry_m};
        if (set_h >= {1'b0, otc_pkg::HOURS_PER_DAY})
        begin
            set_h = set_h - {1'b0, otc_pkg::HOURS_PER_DAY};
            set_m = 7'd0;
            set_s = 7'd0;
        end
    end

    // Next state for one event.
    always_comb
    begin
        rt_next     = rt_reg;
        cook_next   = cook_reg;
        phase_next  = phase_reg;
        heater_next = heater_reg;
        step_next   = step_reg;
        view_next   = view_reg;
        tod_s_next  = tod_s_reg;
        tod_m_next  = tod_m_reg;
        tod_h_next  = tod_h_reg;
        buzz_next   = 1'b0;

        case (s_tuser)
            otc_pkg::CMD_TICK:
            begin
                if (cook_reg && (rt_reg != 16'd0))
                begin
                    rt_next = rt_dec;
                    if (rt_dec == 16'd0)
                    begin
                        cook_next   = 1'b0;
                        heater_next = 1'b0;
                        buzz_next   = 1'b1;
                    end
                end
                // Time of day advances one second.
                if (tod_s_reg == otc_pkg::SECS_PER_MIN - 6'd1)
                begin
                    tod_s_next = 6'd0;
                    if (tod_m_reg == otc_pkg::SECS_PER_MIN - 6'd1)
                    begin
                        tod_m_next = 6'd0;
                        if (tod_h_reg == otc_pkg::HOURS_PER_DAY - 5'd1)
                            tod_h_next = 5'd0;
                        else
                            tod_h_next = tod_h_reg + 5'd1;
                    end
                    else
                    begin
                        tod_m_next = tod_m_reg + 6'd1;
                    end
                end
                else
                begin
                    tod_s_next = tod_s_reg + 6'd1;
                end
            end
            otc_pkg::CMD_MODE:
            begin
                step_next = (step_reg < otc_pkg::STEP_1H) ? step_reg + 3'd1 : otc_pkg::STEP_1S;
            end
            otc_pkg::CMD_HEAT:
            begin
                cook_next  = phase_reg;
                phase_next = !phase_reg;
            end
            otc_pkg::CMD_STOP:
            begin
                cook_next   = 1'b0;
                heater_next = 1'b0;
            end
            otc_pkg::CMD_UP:
            begin
                if (view_reg == otc_pkg::VIEW_COOK)
                begin
                    if (step_reg <= otc_pkg::STEP_1H)
                        rt_next = (up_sum > {1'b0, max_cook_reg}) ? max_cook_reg
                                                                   : up_sum[15:0];
                end
                else if (view_reg == otc_pkg::VIEW_CLOCK)
                begin
                    tod_s_next = set_s[5:0];
                    tod_m_next = set_m[5:0];
                    tod_h_next = set_h[4:0];
                end
            end
            otc_pkg::CMD_DOWN:
            begin
                rt_next = (rt_reg > {4'd0, step_amt}) ? rt_reg - {4'd0, step_amt} : 16'd0;
            end
            otc_pkg::CMD_RESET:
            begin
                cook_next   = 1'b0;
                heater_next = 1'b0;
                rt_next     = 16'd0;
            end
            otc_pkg::CMD_VIEW:
            begin
                if (view_reg == otc_pkg::VIEW_IDLE)
                    view_next = otc_pkg::VIEW_COOK;
                else if (view_reg == otc_pkg::VIEW_COOK)
                    view_next = otc_pkg::VIEW_CLOCK;
                else if (view_reg == otc_pkg::VIEW_CLOCK)
                    view_next = otc_pkg::VIEW_COOK;
            end
            otc_pkg::CMD_TEMP:
            begin
                // Thermostat with a band of +/- band around the setpoint.
                if (cook_reg)
                begin
                    if (meas_lo < {1'b0, setp})
                        heater_next = 1'b1;
                    else if ({1'b0, meas} > setp_hi)
                        heater_next = 1'b0;
                end
            end
            default:
            begin
                buzz_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_reg     <= 16'd0;
            cook_reg   <= 1'b0;
            phase_reg  <= 1'b0;
            heater_reg <= 1'b0;
            step_reg   <= otc_pkg::STEP_1S;
            view_reg   <= otc_pkg::VIEW_IDLE;
            tod_s_reg  <= 6'd0;
            tod_m_reg  <= 6'd0;
            tod_h_reg  <= 5'd0;
        end
        else if (s_accept)
        begin
            rt_reg     <= rt_next;
            cook_reg   <= cook_next;
            phase_reg  <= phase_next;
            heater_reg <= heater_next;
            step_reg   <= step_next;
            view_reg   <= view_next;
            tod_s_reg  <= tod_s_next;
            tod_m_reg  <= tod_m_next;
            tod_h_reg  <= tod_h_next;
        end
    end

    // Display pipeline: status snapshot, hours, remainder, minutes, seconds.
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;
    logic a_ready, b_ready, c_ready, d_ready, e_ready;

    otc_pkg::stat_t a_stat_reg, b_stat_reg, c_stat_reg, d_stat_reg, e_stat_reg;
    otc_pkg::stat_t stat_next;
    logic [15:0] a_rt_reg;
    logic [15:0] b_rt_reg;
    logic [4:0]  b_hours_reg, c_hours_reg, d_hours_reg, e_hours_reg;
    logic [11:0] c_rem_reg, d_rem_reg;
    logic [5:0]  d_min_reg, e_min_reg;
    logic [5:0]  e_sec_reg;

    logic [31:0] hour_prod;
    logic [15:0] hour_secs;
    logic [15:0] rem_full;
    logic [26:0] min_prod;
    logic [11:0] min_secs;
    logic [11:0] sec_full;

    assign e_ready  = !e_valid_reg || m_tready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        stat_next.heater_on     = heater_next;
        stat_next.cooking_on    = cook_next;
        stat_next.clock_hours   = tod_h_next;
        stat_next.clock_minutes = tod_m_next;
        stat_next.clock_seconds = tod_s_next;
        stat_next.step_select   = step_next;
        stat_next.view_select   = view_next;
        stat_next.buzzer_pulse  = buzz_next;
    end

    // Reciprocal multiplies and back-multiplies, one per stage.
    assign hour_prod = a_rt_reg * otc_pkg::RECIP_HOUR;
    assign hour_secs = 16'(b_hours_reg) * 16'(otc_pkg::SECS_PER_HOUR);
    assign rem_full  = b_rt_reg - hour_secs;
    assign min_prod  = c_rem_reg * otc_pkg::RECIP_MIN;
    assign min_secs  = 12'(d_min_reg) * 12'(otc_pkg::SECS_PER_MIN);
    assign sec_full  = d_rem_reg - min_secs;

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= s_tvalid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
            if (d_ready)
                d_valid_reg <= c_valid_reg;
            if (e_ready)
                e_valid_reg <= d_valid_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            a_stat_reg <= stat_next;
            a_rt_reg   <= rt_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_stat_reg  <= a_stat_reg;
            b_rt_reg    <= a_rt_reg;
            b_hours_reg <= hour_prod[31:27];
        end
        if (c_ready && b_valid_reg)
        begin
            c_stat_reg  <= b_stat_reg;
            c_hours_reg <= b_hours_reg;
            c_rem_reg   <= rem_full[11:0];
        end
        if (d_ready && c_valid_reg)
        begin
            d_stat_reg  <= c_stat_reg;
            d_hours_reg <= c_hours_reg;
            d_rem_reg   <= c_rem_reg;
            d_min_reg   <= min_prod[25:20];
        end
        if (e_ready && d_valid_reg)
        begin
            e_stat_reg  <= d_stat_reg;
            e_hours_reg <= d_hours_reg;
            e_min_reg   <= d_min_reg;
            e_sec_reg   <= sec_full[5:0];
        end
    end

    // Output transaction.
    assign m_tvalid = e_valid_reg;
    assign m_tdata  = {6'd0,
                       e_stat_reg.buzzer_pulse,
                       e_stat_reg.view_select,
                       e_stat_reg.step_select,
                       e_stat_reg.clock_seconds,
                       e_stat_reg.clock_minutes,
                       e_stat_reg.clock_hours,
                       e_sec_reg,
                       e_min_reg,
                       e_hours_reg,
                       e_stat_reg.cooking_on,
                       e_stat_reg.heater_on};

    // A buzzer pulse always comes with an empty countdown and heating off.
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && a_stat_reg.buzzer_pulse |->
            (a_rt_reg == 16'd0) && !a_stat_reg.cooking_on && !a_stat_reg.heater_on)
        else $error("buzzer pulse with countdown or heating still active");

    // The time of day never leaves its range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tod_h_reg < otc_pkg::HOURS_PER_DAY) && (tod_m_reg < otc_pkg::SECS_PER_MIN)
            && (tod_s_reg < otc_pkg::SECS_PER_MIN))
        else $error("time of day out of range");

    // The split of the remaining time stays within its digit ranges.
    assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg |-> (e_min_reg < otc_pkg::SECS_PER_MIN)
            && (e_sec_reg < otc_pkg::SECS_PER_MIN) && (e_hours_reg <= 5'd18))
        else $error("remaining time split out of range");

    // The countdown changes only when an event is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_accept |=> $stable(rt_reg))
        else $error("countdown changed without an accepted transaction");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

    // Command codes that the controller must ignore.
    localparam logic [3:0] CMD_SPARE_LO = 4'd9;
    localparam logic [3:0] CMD_SPARE_HI = 4'd15;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 7;

    // Status word laid out as on m_tdata, lowest field last.
    typedef struct packed {
        logic       buzzer_pulse;
        logic [1:0] view_select;
        logic [2:0] step_select;
        logic [5:0] clock_seconds;
        logic [5:0] clock_minutes;
        logic [4:0] clock_hours;
        logic [5:0] remain_seconds;
        logic [5:0] remain_minutes;
        logic [4:0] remain_hours;
        logic       cooking_on;
        logic       heater_on;
    } status_t;

    // One row of the directed event table.
    typedef struct {
        logic [3:0]  cmd;
        logic [13:0] meas;
        logic [13:0] setp;
        bit          typed;
        status_t     want;
    } event_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [3:0]  s_tuser;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // Controller state as the testbench expects it.
    int          cd_secs;
    logic        cook_en;
    logic        heat_phase;
    logic        heater;
    logic [2:0]  step_sel;
    logic [1:0]  view_sel;
    int          tod_h;
    int          tod_m;
    int          tod_s;
    int          lim_secs;
    int          band_tenths;

    status_t     status_due_q[$];
    event_row_t  dir_tbl[$];

    int          errors;
    int          items_sent;
    int          cycle_count;
    int          idle_pct;
    int          stall_pct;
    int          hold_left;

    oven_timer_thermostat_controller dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Countdown increment in seconds for a step code.
    function automatic int increment_secs(input logic [2:0] step);
        int size;
        case (step)
            otc_pkg::STEP_1S:  size = 1;
            otc_pkg::STEP_10S: size = 10;
            otc_pkg::STEP_1M:  size = 60;
            otc_pkg::STEP_10M: size = 600;
            otc_pkg::STEP_1H:  size = 3600;
            default:           size = 0;
        endcase
        return size;
    endfunction

    // Applies one event to the expected state and returns the status it produces.
    function automatic status_t oven_apply_event(input logic [3:0] cmd,
                                                 input logic [13:0] meas,
                                                 input logic [13:0] setp);
        status_t st;
        int      t;
        logic    buzz;
        buzz = 1'b0;
        case (cmd)
            otc_pkg::CMD_TICK:
            begin
                if (cook_en && cd_secs != 0)
                begin
                    cd_secs = cd_secs - 1;
                    if (cd_secs == 0)
                    begin
                        cook_en = 1'b0;
                        heater  = 1'b0;
                        buzz    = 1'b1;
                    end
                end
                tod_s = tod_s + 1;
                if (tod_s >= 60)
                begin
                    tod_s = 0;
                    tod_m = tod_m + 1;
                end
                if (tod_m >= 60)
                begin
                    tod_m = 0;
                    tod_h = tod_h + 1;
                end
                if (tod_h >= 24)
                    tod_h = 0;
            end
            otc_pkg::CMD_MODE:
                step_sel = (step_sel < otc_pkg::STEP_1H) ? step_sel + 3'd1
                                                         : otc_pkg::STEP_1S;
            otc_pkg::CMD_HEAT:
            begin
                cook_en    = heat_phase;
                heat_phase = ~heat_phase;
            end
            otc_pkg::CMD_STOP:
            begin
                cook_en = 1'b0;
                heater  = 1'b0;
            end
            otc_pkg::CMD_UP:
            begin
                if (view_sel == otc_pkg::VIEW_COOK)
                begin
                    if (step_sel <= otc_pkg::STEP_1H)
                    begin
                        t = cd_secs + increment_secs(step_sel);
                        cd_secs = (t > lim_secs) ? lim_secs : t;
                    end
                end
                else if (view_sel == otc_pkg::VIEW_CLOCK)
                begin
                    case (step_sel)
                        otc_pkg::STEP_1S:  tod_s = tod_s + 1;
                        otc_pkg::STEP_10S: tod_s = tod_s + 10;
                        otc_pkg::STEP_1M:  tod_m = tod_m + 1;
                        otc_pkg::STEP_10M: tod_m = tod_m + 10;
                        otc_pkg::STEP_1H:  tod_h = tod_h + 1;
                        default:           ;
                    endcase
                    if (tod_s >= 60)
                    begin
                        tod_s = tod_s - 60;
                        tod_m = tod_m + 1;
                    end
                    if (tod_m >= 60)
                    begin
                        tod_m = tod_m - 60;
                        tod_h = tod_h + 1;
                    end
                    // Setting the clock past midnight also clears minutes and seconds.
                    if (tod_h >= 24)
                    begin
                        tod_h = tod_h - 24;
                        tod_m = 0;
                        tod_s = 0;
                    end
                end
            end
            otc_pkg::CMD_DOWN:
            begin
                t = increment_secs(step_sel);
                cd_secs = (cd_secs > t) ? cd_secs - t : 0;
            end
            otc_pkg::CMD_RESET:
            begin
                cook_en = 1'b0;
                heater  = 1'b0;
                cd_secs = 0;
            end
            otc_pkg::CMD_VIEW:
            begin
                if (view_sel == otc_pkg::VIEW_IDLE || view_sel == otc_pkg::VIEW_CLOCK)
                    view_sel = otc_pkg::VIEW_COOK;
                else if (view_sel == otc_pkg::VIEW_COOK)
                    view_sel = otc_pkg::VIEW_CLOCK;
            end
            otc_pkg::CMD_TEMP:
            begin
                // Thermostat with a symmetric band, active only while cooking.
                if (cook_en)
                begin
                    if (int'(meas) < int'(setp) - band_tenths)
                        heater = 1'b1;
                    else if (int'(meas) > int'(setp) + band_tenths)
                        heater = 1'b0;
                end
            end
            default:
                ;
        endcase
        cd_secs = cd_secs & 16'hFFFF;
        st.heater_on      = heater;
        st.cooking_on     = cook_en;
        st.remain_hours   = 5'(cd_secs / 3600);
        st.remain_minutes = 6'((cd_secs % 3600) / 60);
        st.remain_seconds = 6'(cd_secs % 60);
        st.clock_hours    = 5'(tod_h);
        st.clock_minutes  = 6'(tod_m);
        st.clock_seconds  = 6'(tod_s);
        st.step_select    = step_sel;
        st.view_select    = view_sel;
        st.buzzer_pulse   = buzz;
        return st;
    endfunction

    function automatic status_t mk_status(input int h, input int c, input int rh,
                                          input int rm, input int rs, input int ch,
                                          input int cm, input int cs,
                                          input logic [2:0] step,
                                          input logic [1:0] view, input int buzz);
        status_t st;
        st.heater_on      = 1'(h);
        st.cooking_on     = 1'(c);
        st.remain_hours   = 5'(rh);
        st.remain_minutes = 6'(rm);
        st.remain_seconds = 6'(rs);
        st.clock_hours    = 5'(ch);
        st.clock_minutes  = 6'(cm);
        st.clock_seconds  = 6'(cs);
        st.step_select    = step;
        st.view_select    = view;
        st.buzzer_pulse   = 1'(buzz);
        return st;
    endfunction

    task automatic add_row(input logic [3:0] cmd, input logic [13:0] meas,
                           input logic [13:0] setp, input bit typed, input status_t want);
        event_row_t row;
        row.cmd   = cmd;
        row.meas  = meas;
        row.setp  = setp;
        row.typed = typed;
        row.want  = want;
        dir_tbl.push_back(row);
    endtask

    // Offers one event transaction and records its expected status once accepted.
    task automatic offer_event(input logic [3:0] cmd, input logic [13:0] meas,
                               input logic [13:0] setp, input bit typed,
                               input status_t want);
        status_t pred;
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, setp, meas};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = oven_apply_event(cmd, meas, setp);
        status_due_q.push_back(typed ? want : pred);
        items_sent = items_sent + 1;
    endtask

    // Offers a command with temperatures mostly clustered around the thermostat band.
    task automatic offer_cmd(input logic [3:0] cmd);
        int          margin;
        int          mv;
        logic [13:0] setp;
        logic [13:0] meas;
        if ($urandom_range(0, 99) < 12)
        begin
            setp = 14'($urandom);
            meas = 14'($urandom);
        end
        else
        begin
            margin = band_tenths + 10;
            setp = 14'($urandom_range(0, 10000));
            mv = int'(setp) + $urandom_range(0, 2 * margin) - margin;
            if (mv < 0)
                mv = 0;
            if (mv > 16383)
                mv = 16383;
            meas = 14'(mv);
        end
        offer_event(cmd, meas, setp, 1'b0, '0);
    endtask

    task automatic select_step(input logic [2:0] target);
        while (step_sel != target)
            offer_cmd(otc_pkg::CMD_MODE);
    endtask

    function automatic logic [3:0] pick_cmd();
        int r;
        logic [3:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 25)
            cmd = otc_pkg::CMD_TICK;
        else if (r < 35)
            cmd = otc_pkg::CMD_UP;
        else if (r < 43)
            cmd = otc_pkg::CMD_DOWN;
        else if (r < 52)
            cmd = otc_pkg::CMD_MODE;
        else if (r < 58)
            cmd = otc_pkg::CMD_VIEW;
        else if (r < 66)
            cmd = otc_pkg::CMD_HEAT;
        else if (r < 70)
            cmd = otc_pkg::CMD_STOP;
        else if (r < 72)
            cmd = otc_pkg::CMD_RESET;
        else if (r < 94)
            cmd = otc_pkg::CMD_TEMP;
        else
            cmd = 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        return cmd;
    endfunction

    // Register writes happen only while nothing is in flight.
    task automatic write_cfg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == otc_pkg::CFG_MAX_COOK)
            lim_secs = int'(val);
        else
            band_tenths = int'(val[9:0]);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (status_due_q.size() != 0)
            @(posedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors = errors + 1;
        end
    endtask

    // Compare every accepted status transaction with the oldest expectation.
    always @(posedge clk)
    begin : check_status
        status_t got;
        status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[41:0];
            if (status_due_q.size() == 0)
            begin
                $display("%0t: unexpected status transaction, expected none actual %h",
                         $time, m_tdata);
                errors = errors + 1;
            end
            else
            begin
                want = status_due_q.pop_front();
                cmp_field("heater_on", want.heater_on, got.heater_on);
                cmp_field("cooking_on", want.cooking_on, got.cooking_on);
                cmp_field("remain_hours", want.remain_hours, got.remain_hours);
                cmp_field("remain_minutes", want.remain_minutes, got.remain_minutes);
                cmp_field("remain_seconds", want.remain_seconds, got.remain_seconds);
                cmp_field("clock_hours", want.clock_hours, got.clock_hours);
                cmp_field("clock_minutes", want.clock_minutes, got.clock_minutes);
                cmp_field("clock_seconds", want.clock_seconds, got.clock_seconds);
                cmp_field("step_select", want.step_select, got.step_select);
                cmp_field("view_select", want.view_select, got.view_select);
                cmp_field("buzzer_pulse", want.buzzer_pulse, got.buzzer_pulse);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin : receiver
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin : stimulus
        int        lim_tbl[NUM_PHASES];
        int        band_tbl[NUM_PHASES];
        int        goal;
        int        r;
        int        n;
        int        k;
        bit        held;
        status_t   any;
        logic [2:0] target;

        lim_tbl  = '{36000, 1, 65535, 0, 90, 600, 36000};
        band_tbl = '{10, 0, 1023, 1000, 3, 50, 10};
        held = 1'b0;
        any = '0;
        errors = 0;
        items_sent = 0;
        cycle_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = '0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;

        // Expected state after reset.
        cd_secs     = 0;
        cook_en     = 1'b0;
        heat_phase  = 1'b0;
        heater      = 1'b0;
        step_sel    = otc_pkg::STEP_1S;
        view_sel    = otc_pkg::VIEW_IDLE;
        tod_h       = 0;
        tod_m       = 0;
        tod_s       = 0;
        lim_secs    = int'(otc_pkg::MAX_COOK_RESET);
        band_tenths = int'(otc_pkg::BAND_RESET);

        // Directed events: first status after reset, idle view, a buzzer on the
        // last countdown second, the one-second and one-hour steps, floors, thermostat
        // extremes, clock setting, reset and the spare command codes.
        add_row(otc_pkg::CMD_TICK, 14'd0, 14'd0, 1'b1,
                mk_status(0, 0, 0, 0, 0, 0, 0, 1, otc_pkg::STEP_1S, otc_pkg::VIEW_IDLE, 0));
        add_row(otc_pkg::CMD_UP, 14'd16383, 14'd16383, 1'b1,
                mk_status(0, 0, 0, 0, 0, 0, 0, 1, otc_pkg::STEP_1S, otc_pkg::VIEW_IDLE, 0));
        add_row(otc_pkg::CMD_VIEW, 14'd0, 14'd0, 1'b1,
                mk_status(0, 0, 0, 0, 0, 0, 0, 1, otc_pkg::STEP_1S, otc_pkg::VIEW_COOK, 0));
        add_row(otc_pkg::CMD_UP, 14'd0, 14'd0, 1'b1,
                mk_status(0, 0, 0, 0, 1, 0, 0, 1, otc_pkg::STEP_1S, otc_pkg::VIEW_COOK, 0));
        add_row(otc_pkg::CMD_HEAT, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_HEAT, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_TEMP, 14'd0, 14'd10000, 1'b0, any);
        add_row(otc_pkg::CMD_TICK, 14'd0, 14'd0, 1'b1,
                mk_status(0, 0, 0, 0, 0, 0, 0, 2, otc_pkg::STEP_1S, otc_pkg::VIEW_COOK, 1));
        add_row(otc_pkg::CMD_MODE, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_MODE, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_MODE, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_MODE, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_UP, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_UP, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_DOWN, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_MODE, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_DOWN, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_HEAT, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_HEAT, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_TEMP, 14'd0, 14'd16383, 1'b0, any);
        add_row(otc_pkg::CMD_TEMP, 14'd16383, 14'd16383, 1'b0, any);
        add_row(otc_pkg::CMD_TEMP, 14'd16383, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_TICK, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_STOP, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_VIEW, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_UP, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_RESET, 14'd0, 14'd0, 1'b0, any);
        add_row(otc_pkg::CMD_DOWN, 14'd0, 14'd0, 1'b0, any);
        add_row(CMD_SPARE_HI, 14'd16383, 14'd16383, 1'b0, any);
        add_row(CMD_SPARE_LO, 14'd0, 14'd0, 1'b0, any);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tbl[i])
            offer_event(dir_tbl[i].cmd, dir_tbl[i].meas, dir_tbl[i].setp,
                        dir_tbl[i].typed, dir_tbl[i].want);

        // Random phases, each with a register setting and an idling and stall mix.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                write_cfg(otc_pkg::CFG_MAX_COOK, 16'(lim_tbl[ph]));
                write_cfg(otc_pkg::CFG_BAND, 16'(band_tbl[ph]));
            end
            case (ph % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 45;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 45;
                end
                default:
                begin
                    idle_pct = 14;
                    stall_pct = 14;
                end
            endcase
            goal = items_sent + 230;
            while (items_sent < goal)
            begin
                // One long receiver hold-off so the pipeline fills and backs up.
                if (ph == 0 && !held && items_sent > 80)
                begin
                    hold_left = 300;
                    held = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    // Unstructured noise.
                    n = $urandom_range(1, 12);
                    repeat (n) offer_cmd(pick_cmd());
                end
                else if (r < 82)
                begin
                    // Cooking session: short countdown, enable, then run it down for up to 80 events.
                    while (view_sel != otc_pkg::VIEW_COOK)
                        offer_cmd(otc_pkg::CMD_VIEW);
                    select_step($urandom_range(0, 1) ? otc_pkg::STEP_10S
                                                     : otc_pkg::STEP_1S);
                    repeat ($urandom_range(1, 5)) offer_cmd(otc_pkg::CMD_UP);
                    while (!cook_en)
                        offer_cmd(otc_pkg::CMD_HEAT);
                    k = 0;
                    while (cook_en && cd_secs != 0 && k < 80)
                    begin
                        n = $urandom_range(0, 99);
                        if (n < 60)
                            offer_cmd(otc_pkg::CMD_TICK);
                        else if (n < 90)
                            offer_cmd(otc_pkg::CMD_TEMP);
                        else if (n < 95)
                            offer_cmd($urandom_range(0, 1) ? otc_pkg::CMD_UP
                                                           : otc_pkg::CMD_DOWN);
                        else
                            offer_cmd(pick_cmd());
                        k = k + 1;
                    end
                end
                else
                begin
                    // Clock setting, sometimes right up to midnight.
                    while (view_sel != otc_pkg::VIEW_CLOCK)
                        offer_cmd(otc_pkg::CMD_VIEW);
                    if ($urandom_range(0, 99) < 30)
                    begin
                        select_step(otc_pkg::STEP_1H);
                        while (tod_h != otc_pkg::HOURS_PER_DAY - 1)
                            offer_cmd(otc_pkg::CMD_UP);
                        select_step(otc_pkg::STEP_10M);
                        while (tod_m < 50)
                            offer_cmd(otc_pkg::CMD_UP);
                        select_step(otc_pkg::STEP_1M);
                        while (tod_m != otc_pkg::SECS_PER_MIN - 1)
                            offer_cmd(otc_pkg::CMD_UP);
                        select_step(otc_pkg::STEP_10S);
                        while (tod_s < 50)
                            offer_cmd(otc_pkg::CMD_UP);
                        repeat ($urandom_range(10, 20)) offer_cmd(otc_pkg::CMD_TICK);
                    end
                    else
                    begin
                        target = 3'($urandom_range(otc_pkg::STEP_1S, otc_pkg::STEP_1H));
                        select_step(target);
                        repeat ($urandom_range(1, 30)) offer_cmd(otc_pkg::CMD_UP);
                        repeat ($urandom_range(0, 70)) offer_cmd(otc_pkg::CMD_TICK);
                    end
                end
            end
        end

        drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
